>>> rtl/mmtb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmtb_pkg;

   // Largest matrix handled; the stores hold MAX_SIZE * MAX_SIZE element pairs.
   localparam int MAX_SIZE    = 8;
   localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = 3;
   localparam int SIZE_W      = 4;
   localparam int COUNT_W     = 7;
   localparam int ELEM_W      = 16;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int C_W         = 35;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic              store;
      logic [ADDR_W-1:0] store_addr;
      logic              issue;
      logic [ADDR_W-1:0] a_addr;
      logic [ADDR_W-1:0] b_addr;
      logic              first;
      logic              last;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic              final_entry;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic advance;
   } status_type;

   // A size of zero acts as one, and a size above the maximum acts as the maximum.
   function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] size_value);
      logic [SIZE_W-1:0] result;
      if (size_value == '0) begin
         result = SIZE_W'(1);
      end else if (size_value > SIZE_W'(MAX_SIZE)) begin
         result = SIZE_W'(MAX_SIZE);
      end else begin
         result = size_value;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

>>> rtl/mmtb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mmtb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/mmtb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mmtb_ctrl import mmtb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [SIZE_W-1:0] csr_matrix_size,
   input  wire status_type        status,
   output cmd_type                cmd
);

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_MAC  = 1'b1;

   logic               state_ff, state_in;
   logic [SIZE_W-1:0]  size_ff;
   logic [COUNT_W-1:0] load_count_ff, load_count_in;
   logic [SIZE_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [IDX_W-1:0]   col_ff, col_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [ADDR_W-1:0]  a_base_ff, a_base_in;
   logic [ADDR_W-1:0]  b_base_ff, b_base_in;

   logic [SIZE_W-1:0]  eff_size;
   logic [COUNT_W-1:0] count_next;
   logic [COUNT_W-1:0] area;
   logic               complete;
   logic               accept;
   logic               step;
   logic [SIZE_W-1:0]  n_minus_one;
   logic               k_end, col_end, row_end;

   assign eff_size    = effective_size(size_ff);
   assign count_next  = load_count_ff + COUNT_W'(1);
   assign area        = COUNT_W'(COUNT_W'(eff_size) * COUNT_W'(eff_size));
   assign complete    = (count_next >= area);
   assign req_ready   = (state_ff == ST_LOAD);
   assign csr_ready   = 1'b1;
   assign accept      = req_ready && req_valid;
   assign step        = (state_ff == ST_MAC) && status.advance;
   assign n_minus_one = n_ff - SIZE_W'(1);
   assign k_end       = (k_ff == n_minus_one[IDX_W-1:0]);
   assign col_end     = (col_ff == n_minus_one[IDX_W-1:0]);
   assign row_end     = (row_ff == n_minus_one[IDX_W-1:0]);

   always_comb begin
      cmd.store       = accept;
      cmd.store_addr  = load_count_ff[ADDR_W-1:0];
      cmd.issue       = step;
      cmd.a_addr      = a_base_ff + ADDR_W'(k_ff);
      cmd.b_addr      = b_base_ff + ADDR_W'(k_ff);
      cmd.first       = (k_ff == '0);
      cmd.last        = k_end;
      cmd.row         = row_ff;
      cmd.col         = col_ff;
      cmd.final_entry = row_end && col_end;
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      n_in          = n_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      k_in          = k_ff;
      a_base_in     = a_base_ff;
      b_base_in     = b_base_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (complete) begin
                  load_count_in = '0;
                  state_in      = ST_MAC;
                  n_in          = eff_size;
                  row_in        = '0;
                  col_in        = '0;
                  k_in          = '0;
                  a_base_in     = '0;
                  b_base_in     = '0;
               end else begin
                  load_count_in = count_next;
               end
            end
         end
         ST_MAC: begin
            if (step) begin
               if (k_end) begin
                  k_in = '0;
                  if (col_end) begin
                     col_in    = '0;
                     b_base_in = '0;
                     if (row_end) begin
                        state_in = ST_LOAD;
                     end else begin
                        row_in    = row_ff + 1'b1;
                        a_base_in = a_base_ff + ADDR_W'(n_ff);
                     end
                  end else begin
                     col_in    = col_ff + 1'b1;
                     b_base_in = b_base_ff + ADDR_W'(n_ff);
                  end
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         size_ff       <= SIZE_RESET;
         load_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         if (csr_valid && csr_ready) begin
            size_ff <= csr_matrix_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      k_ff      <= k_in;
      a_base_ff <= a_base_in;
      b_base_ff <= b_base_in;
   end

endmodule

`default_nettype wire

>>> rtl/mmtb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mmtb_datapath import mmtb_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   output status_type                    status,
   input  wire logic signed [ELEM_W-1:0] req_a_element,
   input  wire logic signed [ELEM_W-1:0] req_bt_element,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [C_W-1:0]         rsp_c_element,
   output logic [IDX_W-1:0]              rsp_row_index,
   output logic [IDX_W-1:0]              rsp_column_index,
   output logic                          rsp_last_entry
);

   typedef struct packed {
      logic             first;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             final_entry;
   } tag_type;

   logic                     advance;
   logic [ELEM_W-1:0]        a_rd, b_rd;
   logic                     s1_valid_ff, s2_valid_ff;
   tag_type                  s1_tag_ff, s2_tag_ff;
   logic signed [PROD_W-1:0] product_ff;
   logic signed [C_W-1:0]    acc_ff;
   logic signed [C_W-1:0]    sum;
   logic signed [C_W-1:0]    acc_base;
   logic                     load_out;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [C_W-1:0]    rsp_c_ff;
   logic [IDX_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic                     rsp_last_ff;

   // The whole pipeline freezes while a finished entry waits at the output.
   assign advance        = !(rsp_valid_ff && !rsp_ready);
   assign status.advance = advance;

   mmtb_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (cmd.store_addr),
      .wr_data (req_a_element),
      .rd_en   (cmd.issue),
      .rd_addr (cmd.a_addr),
      .rd_data (a_rd)
   );

   mmtb_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_bt_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (cmd.store_addr),
      .wr_data (req_bt_element),
      .rd_en   (cmd.issue),
      .rd_addr (cmd.b_addr),
      .rd_data (b_rd)
   );

   assign acc_base     = s2_tag_ff.first ? '0 : acc_ff;
   assign sum          = acc_base + {{(C_W-PROD_W){product_ff[PROD_W-1]}}, product_ff};
   assign load_out     = advance && s2_valid_ff && s2_tag_ff.last;
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            s1_valid_ff <= cmd.issue;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tag_ff.first       <= cmd.first;
         s1_tag_ff.last        <= cmd.last;
         s1_tag_ff.row         <= cmd.row;
         s1_tag_ff.col         <= cmd.col;
         s1_tag_ff.final_entry <= cmd.final_entry;
         s2_tag_ff             <= s1_tag_ff;
         product_ff            <= $signed(a_rd) * $signed(b_rd);
         if (s2_valid_ff) begin
            acc_ff <= sum;
         end
      end
      if (load_out) begin
         rsp_c_ff    <= sum;
         rsp_row_ff  <= s2_tag_ff.row;
         rsp_col_ff  <= s2_tag_ff.col;
         rsp_last_ff <= s2_tag_ff.final_entry;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_c_element    = rsp_c_ff;
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_last_entry   = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/matrix_multiply_transposed_b.sv
// Square matrix multiplier C = A x B with B supplied already transposed.
// Request channel (req_): each transaction carries one element of A and the element of
// transposed B at the same row-major position, both signed Q8.8. The block stores n*n
// such pairs, one per cycle, while req_ready is high.
// The transaction that completes the load starts the computation: req_ready drops and
// the block streams all n*n entries of C in row-major order on the response channel
// (rsp_), each a full-precision signed Q19.16 dot product with its row and column, and
// rsp_last_entry set on the final entry. Requests are taken again once the last
// multiply-accumulate has been issued, while the final entries are still draining.
// Operation: one multiply-accumulate unit reads both element memories once per cycle while
// the output is not stalled, and each entry sums n products; the last product of an entry
// passes the memory read register and the product register and is added into the output register.
// Configuration (csr_): a write sets the matrix size n; 0 acts as 1 and values above 8
// act as 8. Write it only while the block is idle.
// Reset (synchronous) empties the load count, restores a size of 8 and drops rsp_valid.
// When the receiver stalls, the finished entry holds in the output register and the
// whole multiply pipeline freezes until it is taken; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_transposed_b import mmtb_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [ELEM_W-1:0] req_a_element,
   input  wire logic signed [ELEM_W-1:0] req_bt_element,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [C_W-1:0]         rsp_c_element,
   output logic [IDX_W-1:0]              rsp_row_index,
   output logic [IDX_W-1:0]              rsp_column_index,
   output logic                          rsp_last_entry,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [SIZE_W-1:0]        csr_matrix_size
);

   // Commands carry the store writes and the multiply-accumulate issue with its tags;
   // status tells the controller whether the pipeline may move this cycle.
   cmd_type    cmd;
   status_type status;

   // The controller owns the size register, the load count and the row, column and
   // inner-product counters that walk the two element memories.
   mmtb_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_matrix_size (csr_matrix_size),
      .status          (status),
      .cmd             (cmd)
   );

   // The datapath holds the element memories, the multiplier, the accumulator and
   // the output register.
   mmtb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_a_element    (req_a_element),
      .req_bt_element   (req_bt_element),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_c_element    (rsp_c_element),
      .rsp_row_index    (rsp_row_index),
      .rsp_column_index (rsp_column_index),
      .rsp_last_entry   (rsp_last_entry)
   );

endmodule

`default_nettype wire
